>>> sv/dthm_pkg.sv
// shared types, codes and constants of the drift tube hit merger
// no dependencies; used by the front, queue, back and top files of the block
`default_nettype none

package dthm_pkg;

  localparam int HIT_ENTRIES_DEF = 64;

  // configuration register indexes
  localparam logic CFG_MIN_EDEP  = 1'b0;
  localparam logic CFG_NS_PER_MM = 1'b1;

  localparam logic [19:0] MIN_EDEP_RST  = 20'd100;
  localparam logic [7:0]  NS_PER_MM_RST = 8'd40;

  // request codes
  localparam logic REQ_CLEAR = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  // result status codes
  localparam logic [2:0] ST_CLEARED    = 3'd0;
  localparam logic [2:0] ST_IGNORED    = 3'd1;
  localparam logic [2:0] ST_NEW_HIT    = 3'd2;
  localparam logic [2:0] ST_MERGED_CL  = 3'd3;
  localparam logic [2:0] ST_MERGED_FAR = 3'd4;
  localparam logic [2:0] ST_FULL       = 3'd5;

  typedef enum logic [1:0] {
    K_CLEAR  = 2'd0,
    K_IGNORE = 2'd1,
    K_STEP   = 2'd2
  } kind_t;

  // one classified and computed item handed from front to back
  typedef struct packed {
    kind_t              kind;
    logic [31:0]        edep;
    logic [30:0]        track_id;
    logic [6:0]         station;
    logic [3:0]         plane;
    logic [9:0]         tube;
    logic [31:0]        radius;
    logic [15:0]        angle;
    logic [7:0]         ns_per_mm;
    logic [31:0]        cy;
    logic [31:0]        cz;
    logic [31:0]        hx;
  } job_t;

  // half of a turn in cordic accumulator units
  localparam logic signed [25:0] PI_UNITS = 26'sd8388608;

  // cordic arctangent table, units of pi/2^23
  function automatic logic signed [25:0] atan_val(input logic [4:0] i);
    logic signed [25:0] v;
    case (i)
      5'd0:  v = 26'sd2097152;
      5'd1:  v = 26'sd1238021;
      5'd2:  v = 26'sd654136;
      5'd3:  v = 26'sd332050;
      5'd4:  v = 26'sd166669;
      5'd5:  v = 26'sd83416;
      5'd6:  v = 26'sd41718;
      5'd7:  v = 26'sd20860;
      5'd8:  v = 26'sd10430;
      5'd9:  v = 26'sd5215;
      5'd10: v = 26'sd2608;
      5'd11: v = 26'sd1304;
      5'd12: v = 26'sd652;
      5'd13: v = 26'sd326;
      5'd14: v = 26'sd163;
      5'd15: v = 26'sd81;
      5'd16: v = 26'sd41;
      5'd17: v = 26'sd20;
      5'd18: v = 26'sd10;
      5'd19: v = 26'sd5;
      default: v = 26'sd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

>>> sv/dthm_ifs.sv
// valid/ready channel interfaces for step requests and hit results
// depends on nothing
`default_nettype none

interface dthm_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [31:0]        edep;
  logic [30:0]        track_id;
  logic [19:0]        copy_number;
  logic signed [31:0] pre_x;
  logic signed [31:0] pre_y;
  logic signed [31:0] pre_z;
  logic signed [31:0] post_x;
  logic signed [31:0] post_y;
  logic signed [31:0] post_z;

  modport source (output valid, req_type, edep, track_id, copy_number, pre_x, pre_y, pre_z,
                  post_x, post_y, post_z, input ready);
  modport sink (input valid, req_type, edep, track_id, copy_number, pre_x, pre_y, pre_z,
                post_x, post_y, post_z, output ready);
endinterface

interface dthm_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic [5:0]         entry_index;
  logic [6:0]         station;
  logic [3:0]         plane;
  logic [9:0]         tube;
  logic [31:0]        drift_radius;
  logic signed [15:0] drift_angle;
  logic [39:0]        drift_time;
  logic signed [31:0] hit_along_wire;
  logic signed [31:0] closest_y;
  logic signed [31:0] closest_z;
  logic [31:0]        edep_sum;

  modport source (output valid, status, entry_index, station, plane, tube, drift_radius,
                  drift_angle, drift_time, hit_along_wire, closest_y, closest_z, edep_sum,
                  input ready);
  modport sink (input valid, status, entry_index, station, plane, tube, drift_radius,
                drift_angle, drift_time, hit_along_wire, closest_y, closest_z, edep_sum,
                output ready);
endinterface

`default_nettype wire

>>> sv/dthm_front.sv
// front part: accepts step requests, classifies them and computes the hit geometry
// depends on dthm_pkg and dthm_in_if
`default_nettype none

module dthm_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  dthm_in_if.sink           in_ch,
  input  wire logic [19:0]  min_edep,
  input  wire logic [7:0]   ns_per_mm,
  output logic              job_vld,
  input  wire logic         job_rdy,
  output dthm_pkg::job_t    job
);

  localparam logic [16:0] RECIP_10000 = 17'd107374; // floor(2^30/10000)
  localparam logic [10:0] RECIP_1000  = 11'd1048;   // floor(2^20/1000)

  typedef enum logic [12:0] {
    F_IDLE = 13'b0000000000001,
    F_DEC0 = 13'b0000000000010,
    F_DEC1 = 13'b0000000000100,
    F_DEC2 = 13'b0000000001000,
    F_DEC3 = 13'b0000000010000,
    F_PROD = 13'b0000000100000,
    F_CHK  = 13'b0000001000000,
    F_DIV  = 13'b0000010000000,
    F_LERP = 13'b0000100000000,
    F_SQ   = 13'b0001000000000,
    F_ROOT = 13'b0010000000000,
    F_FIN  = 13'b0100000000000,
    F_PUSH = 13'b1000000000000
  } f_state_t;

  f_state_t state_r, state_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  dthm_pkg::kind_t    kind_r;
  logic [31:0]        edep_r;
  logic [30:0]        track_r;
  logic [19:0]        copy_r;
  logic [7:0]         npm_r;
  logic signed [31:0] px_r, py_r, pz_r, qx_r, qy_r, qz_r;
  logic signed [32:0] dx_r, dy_r, dz_r;
  logic [6:0]         st_r;
  logic [13:0]        rem_r;
  logic [3:0]         pl_r;
  logic [9:0]         tu_r;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] prod_nxt, prod_r;

  logic [65:0]        den_r;
  logic signed [66:0] num_r;
  logic [66:0]        drem_r;
  logic [31:0]        quo_r;
  logic [32:0]        f_r;

  logic signed [31:0] cy_r, cz_r, hx_r;
  logic [63:0]        sq_s_r, sq_res_r, sq_bit_r;
  logic signed [63:0] cx_r, cw_r;
  logic signed [25:0] acc_r, base_r;
  logic               azero_r;
  logic [31:0]        rad_r;
  logic [15:0]        ang_r;

  // copy number decode
  logic [36:0] dq_prod;
  logic [20:0] dq_rem;
  logic [24:0] dp_prod;
  logic [13:0] dp_rem;
  assign dq_prod = 37'(copy_r) * 37'(RECIP_10000);
  assign dq_rem  = 21'(copy_r) - 21'(st_r) * 21'd10000;
  assign dp_prod = 25'(rem_r) * 25'(RECIP_1000);
  assign dp_rem  = rem_r - 14'(pl_r) * 14'd1000;

  // fraction checks
  logic num_pos, num_ge_den, div_need;
  assign num_pos    = !num_r[66] && (num_r != 67'sd0);
  assign num_ge_den = $unsigned(num_r) >= {1'b0, den_r};
  assign div_need   = (den_r != 66'd0) && num_pos && !num_ge_den;

  logic [66:0] div_try;
  logic        div_take;
  logic [31:0] quo_nxt;
  assign div_try  = {drem_r[65:0], 1'b0};
  assign div_take = div_try >= {1'b0, den_r};
  assign quo_nxt  = {quo_r[30:0], div_take};

  // magnitudes of the segment deltas
  logic [32:0] mag_x, mag_y, mag_z;
  assign mag_x = dx_r[32] ? 33'(-dx_r) : 33'(dx_r);
  assign mag_y = dy_r[32] ? 33'(-dy_r) : 33'(dy_r);
  assign mag_z = dz_r[32] ? 33'(-dz_r) : 33'(dz_r);

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      F_PROD: begin
        case (cnt_r)
          5'd0: begin mul_a = 34'(dy_r); mul_b = 34'(dy_r); end
          5'd1: begin mul_a = 34'(dz_r); mul_b = 34'(dz_r); end
          5'd2: begin mul_a = 34'(py_r); mul_b = 34'(dy_r); end
          5'd3: begin mul_a = 34'(pz_r); mul_b = 34'(dz_r); end
          default: ;
        endcase
      end
      F_LERP: begin
        case (cnt_r)
          5'd0: begin mul_a = $signed({1'b0, mag_y}); mul_b = $signed({1'b0, f_r}); end
          5'd1: begin mul_a = $signed({1'b0, mag_z}); mul_b = $signed({1'b0, f_r}); end
          5'd2: begin mul_a = $signed({1'b0, mag_x}); mul_b = $signed({1'b0, f_r}); end
          default: ;
        endcase
      end
      F_SQ: begin
        case (cnt_r)
          5'd0: begin mul_a = 34'(cy_r); mul_b = 34'(cy_r); end
          5'd1: begin mul_a = 34'(cz_r); mul_b = 34'(cz_r); end
          default: ;
        endcase
      end
      default: ;
    endcase
  end
  assign prod_nxt = mul_a * mul_b;

  // rounding of the interpolation product
  logic [64:0]        lr_sum;
  logic [31:0]        lr_rnd;
  logic signed [33:0] lr_base;
  logic               lr_neg;
  logic signed [33:0] lr_res;
  always_comb begin
    lr_base = 34'(px_r);
    lr_neg  = dx_r[32];
    case (cnt_r)
      5'd1: begin lr_base = 34'(py_r); lr_neg = dy_r[32]; end
      5'd2: begin lr_base = 34'(pz_r); lr_neg = dz_r[32]; end
      default: ;
    endcase
  end
  assign lr_sum = {1'b0, prod_r[63:0]} + 65'h0_8000_0000;
  assign lr_rnd = lr_sum[63:32];
  assign lr_res = lr_neg ? lr_base - $signed({2'b00, lr_rnd})
                         : lr_base + $signed({2'b00, lr_rnd});

  // cordic start point
  logic signed [63:0] cy_ext, cz_ext, yy, zz;
  assign cy_ext = 64'(cy_r);
  assign cz_ext = 64'(cz_r);
  assign yy     = cy_r[31] ? -cy_ext : cy_ext;
  assign zz     = cy_r[31] ? -cz_ext : cz_ext;

  logic [63:0]        sq_try;
  logic signed [63:0] cx_sh, cw_sh;
  logic signed [25:0] ang_sum;
  assign sq_try  = sq_res_r + sq_bit_r;
  assign cx_sh   = cx_r >>> cnt_r;
  assign cw_sh   = cw_r >>> cnt_r;
  assign ang_sum = acc_r + base_r + 26'sd128;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      F_IDLE: begin
        cnt_nxt = 5'd0;
        if (in_ch.valid) begin
          if (in_ch.req_type == dthm_pkg::REQ_CLEAR || in_ch.edep < 32'(min_edep)) begin
            state_nxt = F_PUSH;
          end else begin
            state_nxt = F_DEC0;
          end
        end
      end
      F_DEC0: state_nxt = F_DEC1;
      F_DEC1: state_nxt = F_DEC2;
      F_DEC2: state_nxt = F_DEC3;
      F_DEC3: state_nxt = F_PROD;
      F_PROD: begin
        if (cnt_r == 5'd4) begin
          state_nxt = F_CHK;
          cnt_nxt   = 5'd0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      F_CHK: begin
        cnt_nxt   = 5'd0;
        state_nxt = div_need ? F_DIV : F_LERP;
      end
      F_DIV: begin
        if (cnt_r == 5'd31) begin
          state_nxt = F_LERP;
          cnt_nxt   = 5'd0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      F_LERP: begin
        if (cnt_r == 5'd3) begin
          state_nxt = F_SQ;
          cnt_nxt   = 5'd0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      F_SQ: begin
        if (cnt_r == 5'd2) begin
          state_nxt = F_ROOT;
          cnt_nxt   = 5'd0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      F_ROOT: begin
        if (cnt_r == 5'd31) begin
          state_nxt = F_FIN;
          cnt_nxt   = 5'd0;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      F_FIN: state_nxt = F_PUSH;
      F_PUSH: begin
        if (job_rdy) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= 5'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    case (state_r)
      F_IDLE: begin
        edep_r  <= in_ch.edep;
        track_r <= in_ch.track_id;
        copy_r  <= in_ch.copy_number;
        npm_r   <= ns_per_mm;
        px_r    <= in_ch.pre_x;
        py_r    <= in_ch.pre_y;
        pz_r    <= in_ch.pre_z;
        qx_r    <= in_ch.post_x;
        qy_r    <= in_ch.post_y;
        qz_r    <= in_ch.post_z;
        if (in_ch.req_type == dthm_pkg::REQ_CLEAR) begin
          kind_r <= dthm_pkg::K_CLEAR;
        end else if (in_ch.edep < 32'(min_edep)) begin
          kind_r <= dthm_pkg::K_IGNORE;
        end else begin
          kind_r <= dthm_pkg::K_STEP;
        end
      end
      F_DEC0: begin
        st_r <= dq_prod[36:30];
        dx_r <= 33'(qx_r) - 33'(px_r);
        dy_r <= 33'(qy_r) - 33'(py_r);
        dz_r <= 33'(qz_r) - 33'(pz_r);
      end
      F_DEC1: begin
        if (dq_rem >= 21'd10000) begin
          st_r  <= st_r + 7'd1;
          rem_r <= 14'(dq_rem - 21'd10000);
        end else begin
          rem_r <= dq_rem[13:0];
        end
      end
      F_DEC2: pl_r <= dp_prod[23:20];
      F_DEC3: begin
        if (dp_rem >= 14'd1000) begin
          pl_r <= pl_r + 4'd1;
          tu_r <= 10'(dp_rem - 14'd1000);
        end else begin
          tu_r <= dp_rem[9:0];
        end
      end
      F_PROD: begin
        case (cnt_r)
          5'd1: den_r <= prod_r[65:0];
          5'd2: den_r <= den_r + prod_r[65:0];
          5'd3: num_r <= -prod_r[66:0];
          5'd4: num_r <= num_r - prod_r[66:0];
          default: ;
        endcase
      end
      F_CHK: begin
        drem_r <= $unsigned(num_r);
        quo_r  <= 32'd0;
        if (den_r == 66'd0 || !num_pos) begin
          f_r <= 33'd0;
        end else if (num_ge_den) begin
          f_r <= 33'h1_0000_0000;
        end
      end
      F_DIV: begin
        drem_r <= div_take ? div_try - {1'b0, den_r} : div_try;
        quo_r  <= quo_nxt;
        if (cnt_r == 5'd31) begin
          f_r <= {1'b0, quo_nxt};
        end
      end
      F_LERP: begin
        case (cnt_r)
          5'd1: cy_r <= lr_res[31:0];
          5'd2: cz_r <= lr_res[31:0];
          5'd3: hx_r <= lr_res[31:0];
          default: ;
        endcase
      end
      F_SQ: begin
        case (cnt_r)
          5'd0: begin
            azero_r <= (cy_r == 32'sd0) && (cz_r == 32'sd0);
            cx_r    <= yy <<< 28;
            cw_r    <= zz <<< 28;
            acc_r   <= 26'sd0;
            if (!cy_r[31]) begin
              base_r <= 26'sd0;
            end else if (zz <= 64'sd0) begin
              base_r <= dthm_pkg::PI_UNITS;
            end else begin
              base_r <= -dthm_pkg::PI_UNITS;
            end
          end
          5'd1: sq_s_r <= prod_r[63:0];
          5'd2: begin
            sq_s_r   <= sq_s_r + prod_r[63:0];
            sq_res_r <= 64'd0;
            sq_bit_r <= 64'h4000_0000_0000_0000;
          end
          default: ;
        endcase
      end
      F_ROOT: begin
        if (sq_s_r >= sq_try) begin
          sq_s_r   <= sq_s_r - sq_try;
          sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_r <= sq_res_r >> 1;
        end
        sq_bit_r <= sq_bit_r >> 2;
        if (cnt_r < 5'd20) begin
          if (!cw_r[63]) begin
            cx_r  <= cx_r + cw_sh;
            cw_r  <= cw_r - cx_sh;
            acc_r <= acc_r + dthm_pkg::atan_val(cnt_r);
          end else begin
            cx_r  <= cx_r - cw_sh;
            cw_r  <= cw_r + cx_sh;
            acc_r <= acc_r - dthm_pkg::atan_val(cnt_r);
          end
        end
      end
      F_FIN: begin
        rad_r <= (sq_s_r > sq_res_r) ? 32'(sq_res_r + 64'd1) : sq_res_r[31:0];
        ang_r <= azero_r ? 16'd0 : ang_sum[23:8];
      end
      default: ;
    endcase
  end

  assign in_ch.ready = (state_r == F_IDLE);
  assign job_vld     = (state_r == F_PUSH);

  assign job.kind      = kind_r;
  assign job.edep      = edep_r;
  assign job.track_id  = track_r;
  assign job.station   = st_r;
  assign job.plane     = pl_r;
  assign job.tube      = tu_r;
  assign job.radius    = rad_r;
  assign job.angle     = ang_r;
  assign job.ns_per_mm = npm_r;
  assign job.cy        = cy_r;
  assign job.cz        = cz_r;
  assign job.hx        = hx_r;

endmodule

`default_nettype wire

>>> sv/dthm_queue.sv
// two-entry queue of classified items between front and back
// depends on dthm_pkg
`default_nettype none

module dthm_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_vld,
  output logic                 push_rdy,
  input  wire dthm_pkg::job_t  push_data,
  output logic                 pop_vld,
  input  wire logic            pop_rdy,
  output dthm_pkg::job_t       pop_data
);

  dthm_pkg::job_t slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] fill_r;
  logic       do_push, do_pop;

  assign push_rdy = (fill_r != 2'd2);
  assign pop_vld  = (fill_r != 2'd0);
  assign pop_data = slot_r[rd_ptr_r];
  assign do_push  = push_vld && push_rdy;
  assign do_pop   = pop_vld && pop_rdy;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (do_push) wr_ptr_r <= ~wr_ptr_r;
      if (do_pop)  rd_ptr_r <= ~rd_ptr_r;
      fill_r <= fill_r + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

>>> sv/dthm_back.sv
// back part: hit table search, merge and result register
// depends on dthm_pkg and dthm_out_if
`default_nettype none

module dthm_back #(
  parameter int HIT_ENTRIES = dthm_pkg::HIT_ENTRIES_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            job_vld,
  output logic                 job_rdy,
  input  wire dthm_pkg::job_t  job,
  dthm_out_if.source           out_ch
);

  localparam int AW = (HIT_ENTRIES > 1) ? $clog2(HIT_ENTRIES) : 1;
  localparam int CW = $clog2(HIT_ENTRIES + 1);

  typedef struct packed {
    logic [51:0] key;
    logic [31:0] radius;
    logic [15:0] angle;
    logic [7:0]  ns_per_mm;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [31:0] hx;
    logic [31:0] sum;
  } entry_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  index;
    logic [6:0]  station;
    logic [3:0]  plane;
    logic [9:0]  tube;
    entry_t      ent;
  } res_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_SRCH = 2'b10
  } b_state_t;

  entry_t         mem [HIT_ENTRIES];
  entry_t         rdata_r;
  b_state_t       state_r;
  logic [CW-1:0]  count_r, scan_r, cmp_idx_r;
  logic           cmp_vld_r;
  dthm_pkg::job_t job_r;
  logic           out_vld_r;
  res_t           out_r;

  logic [51:0] job_key;
  logic        match, scan_done, full, closer;
  logic [32:0] sum_wide;
  logic [31:0] sum_sat;
  entry_t      new_ent, upd_ent, mem_wd;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  res_t        clr_res, ign_res;

  assign job_key   = {job_r.tube, job_r.plane, job_r.station, job_r.track_id};
  assign match     = cmp_vld_r && (rdata_r.key == job_key);
  assign scan_done = scan_r >= count_r;
  assign full      = count_r >= CW'(HIT_ENTRIES);
  assign closer    = job_r.radius < rdata_r.radius;
  assign sum_wide  = {1'b0, rdata_r.sum} + {1'b0, job_r.edep};
  assign sum_sat   = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];

  // results of clear and ignored requests carry only the status
  always_comb begin
    clr_res        = '0;
    clr_res.status = dthm_pkg::ST_CLEARED;
    ign_res        = '0;
    ign_res.status = dthm_pkg::ST_IGNORED;
  end

  always_comb begin
    new_ent.key       = job_key;
    new_ent.radius    = job_r.radius;
    new_ent.angle     = job_r.angle;
    new_ent.ns_per_mm = job_r.ns_per_mm;
    new_ent.cy        = job_r.cy;
    new_ent.cz        = job_r.cz;
    new_ent.hx        = job_r.hx;
    new_ent.sum       = job_r.edep;
    upd_ent           = closer ? new_ent : rdata_r;
    upd_ent.sum       = sum_sat;
  end

  assign mem_we = (state_r == B_SRCH) && (match || (scan_done && !full));
  assign mem_wa = match ? cmp_idx_r[AW-1:0] : count_r[AW-1:0];
  assign mem_wd = match ? upd_ent : new_ent;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[scan_r[AW-1:0]];
  end

  assign job_rdy = (state_r == B_IDLE) && !out_vld_r;

  always_ff @(posedge clk) begin
    cmp_idx_r <= scan_r;
    if (!rst_n) begin
      state_r   <= B_IDLE;
      count_r   <= '0;
      scan_r    <= '0;
      cmp_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      cmp_vld_r <= (state_r == B_SRCH) && !scan_done && !match;
      if (out_vld_r && out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
      case (state_r)
        B_IDLE: begin
          scan_r <= '0;
          if (job_vld && !out_vld_r) begin
            job_r <= job;
            case (job.kind)
              dthm_pkg::K_CLEAR: begin
                count_r   <= '0;
                out_r     <= clr_res;
                out_vld_r <= 1'b1;
              end
              dthm_pkg::K_IGNORE: begin
                out_r     <= ign_res;
                out_vld_r <= 1'b1;
              end
              dthm_pkg::K_STEP: state_r <= B_SRCH;
              default: ;
            endcase
          end
        end
        B_SRCH: begin
          scan_r <= scan_r + CW'(1);
          out_r.station <= job_r.station;
          out_r.plane   <= job_r.plane;
          out_r.tube    <= job_r.tube;
          if (match) begin
            out_r.status <= closer ? dthm_pkg::ST_MERGED_CL : dthm_pkg::ST_MERGED_FAR;
            out_r.index  <= 6'(cmp_idx_r);
            out_r.ent    <= upd_ent;
            out_vld_r    <= 1'b1;
            state_r      <= B_IDLE;
          end else if (scan_done) begin
            out_r.ent <= new_ent;
            if (full) begin
              out_r.status <= dthm_pkg::ST_FULL;
              out_r.index  <= 6'd0;
            end else begin
              out_r.status <= dthm_pkg::ST_NEW_HIT;
              out_r.index  <= 6'(count_r);
              count_r      <= count_r + CW'(1);
            end
            out_vld_r <= 1'b1;
            state_r   <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.status         = out_r.status;
  assign out_ch.entry_index    = out_r.index;
  assign out_ch.station        = out_r.station;
  assign out_ch.plane          = out_r.plane;
  assign out_ch.tube           = out_r.tube;
  assign out_ch.drift_radius   = out_r.ent.radius;
  assign out_ch.drift_angle    = out_r.ent.angle;
  assign out_ch.drift_time     = 40'(out_r.ent.radius) * 40'(out_r.ent.ns_per_mm);
  assign out_ch.hit_along_wire = out_r.ent.hx;
  assign out_ch.closest_y      = out_r.ent.cy;
  assign out_ch.closest_z      = out_r.ent.cz;
  assign out_ch.edep_sum       = out_r.ent.sum;

endmodule

`default_nettype wire

>>> sv/drift_tube_hit_merger_top.sv
// Drift tube hit merger. Each step request yields exactly one result. A step is
// taken by the front part through the copy number decode, the products, a
// restoring division of the closest-point fraction when needed (it is settled
// directly when there is no motion in Y-Z, the step moves away, or the closest
// point lies past the end), the interpolation and the 32-step square root with
// the 20-step cordic running beside it. Clear and ignored requests go from
// acceptance straight to the push state. The back part then scans the hit table
// one entry a cycle; a two-entry queue lets front and back work on different
// items. Sustained rate is set by the slower of the two. The table needs no
// clearing pass.
// depends on dthm_pkg, dthm_ifs, dthm_front, dthm_queue, dthm_back
`default_nettype none

module drift_tube_hit_merger_top #(
  parameter int HIT_ENTRIES = dthm_pkg::HIT_ENTRIES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic         cfg_idx,
  input  wire logic [19:0]  cfg_wdata,
  dthm_in_if.sink           in_ch,
  dthm_out_if.source        out_ch
);

  // configuration registers
  logic [19:0] min_edep_r;
  logic [7:0]  ns_per_mm_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_edep_r  <= dthm_pkg::MIN_EDEP_RST;
      ns_per_mm_r <= dthm_pkg::NS_PER_MM_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        dthm_pkg::CFG_MIN_EDEP:  min_edep_r  <= cfg_wdata;
        dthm_pkg::CFG_NS_PER_MM: ns_per_mm_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // front to queue transfer
  logic           f_vld, f_rdy;
  dthm_pkg::job_t f_job;
  // queue to back transfer
  logic           b_vld, b_rdy;
  dthm_pkg::job_t b_job;

  // classify, decode and compute geometry
  dthm_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .min_edep  (min_edep_r),
    .ns_per_mm (ns_per_mm_r),
    .job_vld   (f_vld),
    .job_rdy   (f_rdy),
    .job       (f_job)
  );

  // decouples the two sides
  dthm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_vld  (f_vld),
    .push_rdy  (f_rdy),
    .push_data (f_job),
    .pop_vld   (b_vld),
    .pop_rdy   (b_rdy),
    .pop_data  (b_job)
  );

  // hit table merge and result register
  dthm_back #(
    .HIT_ENTRIES (HIT_ENTRIES)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .job_vld (b_vld),
    .job_rdy (b_rdy),
    .job     (b_job),
    .out_ch  (out_ch)
  );

endmodule

`default_nettype wire
